// ===== rtl/mbe_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and helper functions of the Mandelbrot escape counter.
// No dependencies; every other file imports this package.
package mbe_pkg;

  localparam int WORD_W        = 32;
  localparam int PROD_W        = 2 * WORD_W;
  localparam int DIGIT_W       = 4;
  localparam int MUL_STEPS     = WORD_W / DIGIT_W;
  localparam int STEP_W        = $clog2(MUL_STEPS);
  localparam int CNT_W         = 16;
  localparam int POS_W         = 10;
  localparam int STEP_REG_W    = 31;
  localparam int ADDR_W        = 5;
  localparam int FRAC_BITS_DEF = 28;

  localparam logic [ADDR_W-1:0] ADDR_RE_ORIGIN = 5'h00;
  localparam logic [ADDR_W-1:0] ADDR_RE_STEP   = 5'h04;
  localparam logic [ADDR_W-1:0] ADDR_IM_ORIGIN = 5'h08;
  localparam logic [ADDR_W-1:0] ADDR_IM_STEP   = 5'h0C;
  localparam logic [ADDR_W-1:0] ADDR_LIMIT     = 5'h10;

  localparam logic signed [WORD_W-1:0]   RST_RE_ORIGIN = -32'sd536870912;
  localparam logic [STEP_REG_W-1:0]      RST_RE_STEP   = 31'd1792539;
  localparam logic signed [WORD_W-1:0]   RST_IM_ORIGIN = 32'sd402653184;
  localparam logic [STEP_REG_W-1:0]      RST_IM_STEP   = 31'd1344404;
  localparam logic [CNT_W-1:0]           RST_LIMIT     = 16'd100;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COORD,
    ST_CHECK,
    ST_MUL,
    ST_UPDATE
  } state_t;

  // Clamp a 64-bit signed value into the signed 32-bit range.
  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[WORD_W-1:0];
  endfunction

  // Magnitude of a signed word; the most negative value maps to 2^31.
  function automatic logic [WORD_W-1:0] mag32(input logic signed [WORD_W-1:0] v);
    logic [WORD_W-1:0] u;
    u = v;
    return u[WORD_W-1] ? (~u + 32'd1) : u;
  endfunction

endpackage

// ===== rtl/mandelbrot_escape_count.sv =====
`timescale 1ns / 1ps
// Top level of the Mandelbrot escape-time counter: register file, sequencer, update.
// Depends on mbe_pkg and mbe_serial_mul.
//
// Usage: a request is a pixel (in_row, in_col), taken at a rising edge where
// start is high and busy is low. The pixel is mapped to c = cx + i*cy from
// the view registers, and z = z*z + c is iterated from zero in signed fixed
// point until |z|^2 reaches 4 or the iteration limit is hit.
// The result (out_iter_count, out_in_set) appears for exactly one cycle with
// out_valid high; the receiver cannot stall and must take it then.
// Each iteration passes through a check state, the digit-serial multiplier
// steps that form x*x, y*y and x*y, and an update state. A pixel that
// reaches the limit takes its result from the check state; one that escapes
// takes it from the update state. One pixel is in flight at a time; busy
// drops in the result cycle, so the next request can be taken then.
// The view registers sit on an APB-style port at byte addresses 0, 4, 8, 12
// and 16 and should be written only while busy is low.
// Reset (rst_n low, synchronous) returns the sequencer to idle, drops
// out_valid and loads the default view of the full set with a limit of 100.
module mandelbrot_escape_count import mbe_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [POS_W-1:0]        in_row,
  input  logic [POS_W-1:0]        in_col,
  output logic                    out_valid,
  output logic [CNT_W-1:0]        out_iter_count,
  output logic                    out_in_set,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [WORD_W-1:0]       pwdata,
  output logic [WORD_W-1:0]       prdata,
  output logic                    pready
);

  // The point escapes once x*x + y*y reaches 4 in the squared scale.
  localparam int ESC_SHIFT = 2 * FRAC_BITS + 2;

  logic signed [WORD_W-1:0]   re_origin_r;
  logic [STEP_REG_W-1:0]      re_step_r;
  logic signed [WORD_W-1:0]   im_origin_r;
  logic [STEP_REG_W-1:0]      im_step_r;
  logic [CNT_W-1:0]           limit_r;

  state_t                     state_r, state_nxt;
  logic [POS_W-1:0]           row_r, row_nxt;
  logic [POS_W-1:0]           col_r, col_nxt;
  logic signed [WORD_W-1:0]   cx_r, cx_nxt;
  logic signed [WORD_W-1:0]   cy_r, cy_nxt;
  logic signed [WORD_W-1:0]   x_r, x_nxt;
  logic signed [WORD_W-1:0]   y_r, y_nxt;
  logic                       neg_r, neg_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [STEP_W-1:0]          step_r, step_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]           out_count_r, out_count_nxt;
  logic                       out_in_set_r, out_in_set_nxt;

  logic                       mul_load;
  logic                       mul_en;
  logic [WORD_W-1:0]          x_mag;
  logic [WORD_W-1:0]          y_mag;
  logic [PROD_W-1:0]          xx;
  logic [PROD_W-1:0]          yy;
  logic [PROD_W-1:0]          xy_mag;
  logic [PROD_W-1:0]          mag_sum;
  logic signed [PROD_W-1:0]   xy_s;
  logic signed [PROD_W-1:0]   diff;
  logic signed [PROD_W-1:0]   cx_full;
  logic signed [PROD_W-1:0]   cy_full;
  logic                       escaped;
  logic                       cfg_wr;

  assign x_mag = mag32(x_r);
  assign y_mag = mag32(y_r);

  mbe_serial_mul u_mul_xx (
    .clk  (clk),
    .load (mul_load),
    .en   (mul_en),
    .a    (x_mag),
    .b    (x_mag),
    .prod (xx)
  );

  mbe_serial_mul u_mul_yy (
    .clk  (clk),
    .load (mul_load),
    .en   (mul_en),
    .a    (y_mag),
    .b    (y_mag),
    .prod (yy)
  );

  mbe_serial_mul u_mul_xy (
    .clk  (clk),
    .load (mul_load),
    .en   (mul_en),
    .a    (x_mag),
    .b    (y_mag),
    .prod (xy_mag)
  );

  // Configuration port: zero wait states, writes complete in the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (paddr)
      ADDR_RE_ORIGIN: prdata = re_origin_r;
      ADDR_RE_STEP:   prdata = {1'b0, re_step_r};
      ADDR_IM_ORIGIN: prdata = im_origin_r;
      ADDR_IM_STEP:   prdata = {1'b0, im_step_r};
      ADDR_LIMIT:     prdata = {{(WORD_W-CNT_W){1'b0}}, limit_r};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      re_origin_r <= RST_RE_ORIGIN;
      re_step_r   <= RST_RE_STEP;
      im_origin_r <= RST_IM_ORIGIN;
      im_step_r   <= RST_IM_STEP;
      limit_r     <= RST_LIMIT;
    end else if (cfg_wr) begin
      case (paddr)
        ADDR_RE_ORIGIN: re_origin_r <= pwdata;
        ADDR_RE_STEP:   re_step_r   <= pwdata[STEP_REG_W-1:0];
        ADDR_IM_ORIGIN: im_origin_r <= pwdata;
        ADDR_IM_STEP:   im_step_r   <= pwdata[STEP_REG_W-1:0];
        ADDR_LIMIT:     limit_r     <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Update arithmetic. The squares are non-negative and below 2^63, so the
  // signed views of them and of their difference never overflow. The
  // arithmetic shifts round toward minus infinity.
  assign mag_sum = xx + yy;
  assign escaped = (mag_sum >> ESC_SHIFT) != '0;
  assign diff    = $signed(xx) - $signed(yy);
  assign xy_s    = neg_r ? -$signed(xy_mag) : $signed(xy_mag);
  assign cx_full = PROD_W'(cx_r);
  assign cy_full = PROD_W'(cy_r);

  always_comb begin
    state_nxt      = state_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    cx_nxt         = cx_r;
    cy_nxt         = cy_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    neg_nxt        = neg_r;
    count_nxt      = count_r;
    step_nxt       = step_r;
    out_valid_nxt  = 1'b0;
    out_count_nxt  = out_count_r;
    out_in_set_nxt = out_in_set_r;
    mul_load       = 1'b0;
    mul_en         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          row_nxt   = in_row;
          col_nxt   = in_col;
          state_nxt = ST_COORD;
        end
      end
      ST_COORD: begin
        // Pixel to plane: one small multiply per axis, then clamp.
        cx_nxt    = sat32(PROD_W'(re_origin_r)
                    + $signed(PROD_W'(col_r) * PROD_W'(re_step_r)));
        cy_nxt    = sat32(PROD_W'(im_origin_r)
                    - $signed(PROD_W'(row_r) * PROD_W'(im_step_r)));
        x_nxt     = '0;
        y_nxt     = '0;
        count_nxt = '0;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (count_r == limit_r) begin
          out_valid_nxt  = 1'b1;
          out_count_nxt  = count_r;
          out_in_set_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          mul_load  = 1'b1;
          neg_nxt   = x_r[WORD_W-1] ^ y_r[WORD_W-1];
          step_nxt  = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        mul_en   = 1'b1;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(MUL_STEPS - 1)) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (escaped) begin
          out_valid_nxt  = 1'b1;
          out_count_nxt  = count_r;
          out_in_set_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end else begin
          x_nxt     = sat32((diff >>> FRAC_BITS) + cx_full);
          y_nxt     = sat32((xy_s >>> (FRAC_BITS - 1)) + cy_full);
          count_nxt = count_r + 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r        <= row_nxt;
    col_r        <= col_nxt;
    cx_r         <= cx_nxt;
    cy_r         <= cy_nxt;
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    neg_r        <= neg_nxt;
    count_r      <= count_nxt;
    step_r       <= step_nxt;
    out_count_r  <= out_count_nxt;
    out_in_set_r <= out_in_set_nxt;
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_iter_count = out_count_r;
  assign out_in_set     = out_in_set_r;

endmodule

// ===== rtl/mbe_serial_mul.sv =====
`timescale 1ns / 1ps
// Digit-serial unsigned 32x32 multiplier, one 4-bit digit of b per cycle while en is high.
// Depends on mbe_pkg.
module mbe_serial_mul import mbe_pkg::*; (
  input  logic              clk,
  input  logic              load,
  input  logic              en,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  output logic [PROD_W-1:0] prod
);

  logic [WORD_W-1:0]         a_r;
  logic [WORD_W-1:0]         b_r;
  logic [PROD_W-1:0]         acc_r;
  logic [WORD_W+DIGIT_W-1:0] part;
  logic [PROD_W+DIGIT_W-1:0] sum;

  // Partial product enters at the top and the accumulator shifts right one digit.
  assign part = (WORD_W+DIGIT_W)'(a_r) * (WORD_W+DIGIT_W)'(b_r[DIGIT_W-1:0]);
  assign sum  = (PROD_W+DIGIT_W)'(acc_r) + {part, {WORD_W{1'b0}}};
  assign prod = acc_r;

  always_ff @(posedge clk) begin
    if (load) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (en) begin
      acc_r <= sum[PROD_W+DIGIT_W-1:DIGIT_W];
      b_r   <= b_r >> DIGIT_W;
    end
  end

endmodule
